>>> rtl/core/ddw_pkg.sv
// ----------------------------------------------------------------------------
// ddw_pkg
// Shared widths, driver register addresses and status codes for the
// decimal digit display writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ddw_pkg;

	localparam int VALUE_W        = 32;
	localparam int COUNT_W        = 4;
	localparam int ADDR_W         = 4;
	localparam int DATA_W         = 8;
	localparam int STATUS_W       = 2;
	localparam int SHOWN_W        = 5;
	localparam int MAG_W          = 27;
	localparam int REM_W          = 4;
	localparam int RECIP_W        = 28;
	localparam int RECIP_SHIFT    = 31;
	localparam int MAX_DIGITS_DEF = 8;

	localparam logic signed [VALUE_W-1:0] VALUE_HIGH = 32'sd99999999;
	localparam logic signed [VALUE_W-1:0] VALUE_LOW  = -32'sd9999999;

	// ceil(2^31 / 10), exact quotient for every magnitude below 2^30
	localparam logic [RECIP_W-1:0] RECIP_TEN = 28'd214748365;
	localparam logic [REM_W-1:0]   RADIX     = 4'd10;

	localparam logic [ADDR_W-1:0]  ADDR_NONE       = 4'h0;
	localparam logic [ADDR_W-1:0]  ADDR_SCAN_LIMIT = 4'hB;
	localparam logic [ADDR_W-1:0]  ADDR_SHUTDOWN   = 4'hC;

	localparam logic [DATA_W-1:0]  DATA_WAKE       = 8'd1;
	localparam logic [DATA_W-1:0]  DATA_SLEEP      = 8'd0;

	localparam logic [SHOWN_W-1:0] NONE_SET        = 5'd31;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [DATA_W-1:0]         data_t;
	typedef logic [STATUS_W-1:0]       status_t;

endpackage

`default_nettype wire

>>> rtl/core/ddw_if.sv
// ----------------------------------------------------------------------------
// ddw_item_if / ddw_result_if
// Valid/ready channels carrying input items and driver write results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ddw_item_if;
	import ddw_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	count_t digit_count;

	modport source (output valid, output value, output digit_count, input ready);
	modport sink (input valid, input value, input digit_count, output ready);
endinterface

interface ddw_result_if;
	import ddw_pkg::*;

	logic    valid;
	logic    ready;
	logic    write_valid;
	addr_t   reg_address;
	data_t   reg_data;
	logic    last;
	status_t status;

	modport source (
		output valid, output write_valid, output reg_address, output reg_data,
		output last, output status, input ready
	);
	modport sink (
		input valid, input write_valid, input reg_address, input reg_data,
		input last, input status, output ready
	);
endinterface

`default_nettype wire

>>> rtl/core/ddw_div10.sv
// ----------------------------------------------------------------------------
// ddw_div10
// Shared divide-by-ten unit: reciprocal multiply gives the quotient, a
// shift-add back-multiply gives the remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module ddw_div10 (
	input  logic [ddw_pkg::MAG_W-1:0] mag,
	output logic [ddw_pkg::MAG_W-1:0] quot,
	output logic [ddw_pkg::REM_W-1:0] rem
);
	import ddw_pkg::*;

	localparam int PROD_W = MAG_W + RECIP_W;

	logic [PROD_W-1:0] prod;
	logic [MAG_W-1:0]  quot_x10;

	assign prod     = PROD_W'(mag) * PROD_W'(RECIP_TEN);
	assign quot     = prod[RECIP_SHIFT +: MAG_W];
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = REM_W'(mag - quot_x10);

endmodule

`default_nettype wire

>>> rtl/core/decimal_digit_display_writer_unit.sv
// ----------------------------------------------------------------------------
// decimal_digit_display_writer_unit
// Turns a signed value and a digit count into register writes for an
// eight-digit seven-segment driver.
// ----------------------------------------------------------------------------
// One item is taken while the unit is idle; a small sequencer then issues
// one result beat per cycle while the result side is ready: an optional wake
// write and a scan limit or shutdown write when the digit count changes,
// then one digit write per digit, each digit produced by a single shared
// divide-by-ten unit. A stall on the result side holds the sequencer, and a
// new item is taken only after the last beat of the one before is issued.
// Out-of-range items give one status beat with a range error; items that
// need no write give one status beat.
`default_nettype none

module decimal_digit_display_writer_unit #(
	parameter int MAX_DIGITS = ddw_pkg::MAX_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ddw_item_if.sink              item,
	ddw_result_if.source          result
);
	import ddw_pkg::*;

	localparam int IDX_W = $clog2(MAX_DIGITS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WAKE  = 3'd1;
	localparam logic [2:0] S_CTRL  = 3'd2;
	localparam logic [2:0] S_DIGIT = 3'd3;
	localparam logic [2:0] S_STAT  = 3'd4;

	logic [2:0]         state_q;
	logic [SHOWN_W-1:0] shown_q;
	count_t             cnt_q;
	logic [IDX_W-1:0]   idx_q;
	logic [MAG_W-1:0]   mag_q;
	logic               neg_q;
	status_t            stat_q;

	logic               rv_q;
	logic               wv_q;
	addr_t              addr_q;
	data_t              data_q;
	logic               last_q;
	status_t            status_q;

	logic               take;
	logic               slot_free;
	logic               issue;
	logic               in_range;
	logic               changed;
	value_t             abs_val;
	logic [MAG_W-1:0]   quot;
	logic [REM_W-1:0]   rem;
	logic               digit_last;

	ddw_div10 u_div10 (
		.mag  (mag_q),
		.quot (quot),
		.rem  (rem)
	);

	assign item.ready = (state_q == S_IDLE);
	assign take       = item.valid && item.ready;
	assign slot_free  = !rv_q || result.ready;
	assign issue      = slot_free && (state_q inside {S_WAKE, S_CTRL, S_DIGIT, S_STAT});
	assign in_range   = (item.value <= VALUE_HIGH) && (item.value >= VALUE_LOW)
		&& (item.digit_count <= COUNT_W'(MAX_DIGITS));
	assign changed    = {1'b0, item.digit_count} != shown_q;
	assign abs_val    = item.value[VALUE_W-1] ? -item.value : item.value;
	assign digit_last = (COUNT_W'(idx_q) + COUNT_W'(1)) == cnt_q;

	assign result.valid       = rv_q;
	assign result.write_valid = wv_q;
	assign result.reg_address = addr_q;
	assign result.reg_data    = data_q;
	assign result.last        = last_q;
	assign result.status      = status_q;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			shown_q <= NONE_SET;
			rv_q    <= 1'b0;
		end else begin
			if (issue) begin
				rv_q <= 1'b1;
			end else if (result.ready) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (!in_range) begin
							state_q <= S_STAT;
						end else if (changed) begin
							shown_q <= {1'b0, item.digit_count};
							state_q <= (shown_q == '0) ? S_WAKE : S_CTRL;
						end else if (item.digit_count != '0) begin
							state_q <= S_DIGIT;
						end else begin
							state_q <= S_STAT;
						end
					end
				end
				S_WAKE: begin
					if (slot_free) begin
						state_q <= S_CTRL;
					end
				end
				S_CTRL: begin
					if (slot_free) begin
						state_q <= (cnt_q != '0) ? S_DIGIT : S_IDLE;
					end
				end
				S_DIGIT: begin
					if (slot_free) begin
						if (digit_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_STAT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers and result beat payload
	always_ff @(posedge clk) begin
		if (take) begin
			cnt_q  <= item.digit_count;
			idx_q  <= '0;
			mag_q  <= abs_val[MAG_W-1:0];
			neg_q  <= item.value[VALUE_W-1];
			stat_q <= in_range ? STATUS_OK : STATUS_RANGE;
		end
		if (slot_free) begin
			case (state_q)
				S_WAKE: begin
					wv_q     <= 1'b1;
					addr_q   <= ADDR_SHUTDOWN;
					data_q   <= DATA_WAKE;
					last_q   <= 1'b0;
					status_q <= STATUS_OK;
				end
				S_CTRL: begin
					wv_q <= 1'b1;
					if (cnt_q != '0) begin
						addr_q   <= ADDR_SCAN_LIMIT;
						data_q   <= DATA_W'(cnt_q - COUNT_W'(1));
						last_q   <= 1'b0;
						status_q <= STATUS_OK;
					end else begin
						addr_q   <= ADDR_SHUTDOWN;
						data_q   <= DATA_SLEEP;
						last_q   <= 1'b1;
						status_q <= (mag_q != '0) ? STATUS_TRUNCATED : STATUS_OK;
					end
				end
				S_DIGIT: begin
					wv_q     <= 1'b1;
					addr_q   <= ADDR_W'(idx_q) + ADDR_W'(1);
					data_q   <= neg_q ? (DATA_W'(0) - DATA_W'(rem)) : DATA_W'(rem);
					last_q   <= digit_last;
					status_q <= (digit_last && quot != '0) ? STATUS_TRUNCATED : STATUS_OK;
					mag_q    <= quot;
					idx_q    <= idx_q + IDX_W'(1);
				end
				S_STAT: begin
					wv_q     <= 1'b0;
					addr_q   <= ADDR_NONE;
					data_q   <= '0;
					last_q   <= 1'b1;
					status_q <= stat_q;
				end
				default: begin
				end
			endcase
		end
	end

	a_range_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && status_q == STATUS_RANGE |-> !wv_q && last_q)
		else $error("range error beat carries a write");

	a_status_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		rv_q && !last_q |-> status_q == STATUS_OK)
		else $error("status set on a beat that is not last");

	a_shown_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(shown_q))
		else $error("shown count changed without an accepted item");

	a_digit_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIGIT |-> COUNT_W'(idx_q) < cnt_q)
		else $error("digit index past digit count");

endmodule

`default_nettype wire

>>> tb/tb_decimal_digit_display_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_decimal_digit_display_writer_unit
// Drives signed values and digit counts into the display writer. A scoreboard
// class keeps its own copy of the shown digit count and builds the expected
// driver writes for each accepted item. Each result beat is checked against
// the oldest expected one. The run covers directed corner cases, then random
// items under three idling profiles and one long stall on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_decimal_digit_display_writer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ddw_pkg::*;

	localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
	localparam int DECIMAL_BASE = 10;
	localparam int STALL_CYCLES = 300;
	localparam int PHASE_ITEMS  = 133;
	localparam int NUM_DIRECTED = 23;

	typedef struct packed {
		logic    write_valid;
		addr_t   reg_address;
		data_t   reg_data;
		logic    last;
		status_t status;
	} driver_write_t;

	class digit_write_scoreboard;
		logic [SHOWN_W-1:0] shown_count;
		driver_write_t      pending[$];
		int                 errors;
		int                 items;
		int                 beats;
		int                 range_errors;
		int                 truncations;

		function new();
			shown_count  = NONE_SET;
			errors       = 0;
			items        = 0;
			beats        = 0;
			range_errors = 0;
			truncations  = 0;
		endfunction

		function string show(driver_write_t w);
			return $sformatf("wv=%0b addr=%0d data=0x%02h last=%0b status=%0d",
				w.write_valid, w.reg_address, w.reg_data, w.last, w.status);
		endfunction

		function void note_item(value_t v, count_t c);
			driver_write_t seq[$];
			int            rest;
			int            quot;
			int            digit;
			int            i;
			items++;
			if (v > VALUE_HIGH || v < VALUE_LOW || c > MAX_DIGITS) begin
				range_errors++;
				pending.push_back('{1'b0, ADDR_NONE, data_t'(0), 1'b1, STATUS_RANGE});
				return;
			end
			rest = v;
			if ({1'b0, c} != shown_count) begin
				if (shown_count == '0)
					seq.push_back('{1'b1, ADDR_SHUTDOWN, DATA_WAKE, 1'b0, STATUS_OK});
				shown_count = {1'b0, c};
				if (c != 0)
					seq.push_back('{1'b1, ADDR_SCAN_LIMIT, data_t'(c - 1), 1'b0, STATUS_OK});
				else
					seq.push_back('{1'b1, ADDR_SHUTDOWN, DATA_SLEEP, 1'b0, STATUS_OK});
			end
			for (i = 0; i < c; i++) begin
				quot  = rest / DECIMAL_BASE;
				digit = rest - quot * DECIMAL_BASE;
				seq.push_back('{1'b1, addr_t'(i + 1), data_t'(digit), 1'b0, STATUS_OK});
				rest  = quot;
			end
			if (seq.size() == 0) begin
				seq.push_back('{1'b0, ADDR_NONE, data_t'(0), 1'b1, STATUS_OK});
			end else begin
				seq[$].last   = 1'b1;
				seq[$].status = (rest != 0) ? STATUS_TRUNCATED : STATUS_OK;
				if (rest != 0)
					truncations++;
			end
			foreach (seq[k])
				pending.push_back(seq[k]);
		endfunction

		function void check_beat(driver_write_t got);
			driver_write_t want;
			beats++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result beat with nothing expected: %s", $time, show(got));
				return;
			end
			want = pending.pop_front();
			if (got.write_valid !== want.write_valid || got.reg_address !== want.reg_address ||
					got.reg_data !== want.reg_data || got.last !== want.last ||
					got.status !== want.status) begin
				errors++;
				$display("%0t: mismatch expected %s actual %s", $time, show(want), show(got));
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ddw_item_if   item_ch ();
	ddw_result_if result_ch ();

	decimal_digit_display_writer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	digit_write_scoreboard board;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	bit     stall_request = 1'b0;
	int     stall_left = 0;
	count_t prev_count = '0;

	value_t dir_values [NUM_DIRECTED] = '{
		32'sd0, 32'sd5, 32'sd123, 32'sd99999999, 32'sd100000000, -32'sd9999999,
		-32'sd10000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sd7, 32'sd7, -32'sd3,
		32'sd12345, -32'sd12345, 32'sd0, 32'sd42, 32'sd42, 32'sd42, -32'sd1,
		32'sd10, 32'sd99999999, 32'sd1, -32'sd1
	};
	count_t dir_counts [NUM_DIRECTED] = '{
		4'd0, 4'd0, 4'd3, 4'd8, 4'd8, 4'd8,
		4'd1, 4'd4, 4'd4, 4'd9, 4'd15, 4'd1,
		4'd2, 4'd2, 4'd8, 4'd0, 4'd0, 4'd8, 4'd3,
		4'd1, 4'd0, 4'd5, 4'd15
	};

	always #5 clk = ~clk;

	// result side: check accepted beats, then pick next ready
	always @(posedge clk) begin
		if (arst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			board.check_beat('{result_ch.write_valid, result_ch.reg_address,
				result_ch.reg_data, result_ch.last, result_ch.status});
		if (stall_request) begin
			stall_left    = STALL_CYCLES;
			stall_request = 1'b0;
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic drive_item(input value_t v, input count_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.value       <= v;
		item_ch.digit_count <= c;
		@(posedge clk);
		while (item_ch.ready !== 1'b1)
			@(posedge clk);
		board.note_item(v, c);
		prev_count = c;
	endtask

	task automatic make_random_item(output value_t v, output count_t c);
		int pick;
		int width;
		int mag;
		pick = $urandom_range(99);
		if (pick < 6) begin
			v = $urandom;
			c = count_t'($urandom_range(15));
			return;
		end
		pick = $urandom_range(99);
		if (pick < 15)
			c = '0;
		else if (pick < 40)
			c = prev_count;
		else
			c = count_t'($urandom_range(MAX_DIGITS, 1));
		if ($urandom_range(99) < 5)
			c = count_t'($urandom_range(15, MAX_DIGITS + 1));
		pick = $urandom_range(99);
		if (pick < 4) begin
			case ($urandom_range(3))
				0: v = VALUE_HIGH;
				1: v = VALUE_LOW;
				2: v = VALUE_HIGH + 1;
				default: v = VALUE_LOW - 1;
			endcase
		end else begin
			width = $urandom_range(8);
			mag   = (width == 0) ? 0 : $urandom_range(10 ** width - 1);
			if ($urandom_range(2) == 0 && mag <= -VALUE_LOW)
				v = -mag;
			else
				v = mag;
		end
	endtask

	initial begin
		value_t v;
		count_t c;
		board = new();
		arst_n = 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.value       <= '0;
		item_ch.digit_count <= '0;
		send_idle_pct = 16;
		recv_idle_pct = 76;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			drive_item(dir_values[i], dir_counts[i]);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 76 : 0;
			recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 16 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// long hold-off on the result side while items keep coming
				if (phase == 2 && i == 40)
					stall_request = 1'b1;
				make_random_item(v, c);
				drive_item(v, c);
			end
		end
		item_ch.valid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d items and %0d result beats", board.items, board.beats);
		$display("including %0d out-of-range items and %0d truncated values",
			board.range_errors, board.truncations);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/core/ddw_pkg.sv
rtl/core/ddw_if.sv
rtl/core/ddw_div10.sv
rtl/core/decimal_digit_display_writer_unit.sv
tb/tb_decimal_digit_display_writer_unit.sv
